>>> rtl/core/interleaved_bitmap_scroll_engine_macros.svh
// Assertion macros for the interleaved bitmap scroll engine.
// Included by the controller and the datapath; no other dependencies.
`ifndef INTERLEAVED_BITMAP_SCROLL_ENGINE_MACROS_SVH
`define INTERLEAVED_BITMAP_SCROLL_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, masked while reset is high
`define IBSE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ibse: check failed");
// clocked check that also holds during reset
`define IBSE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ibse: check failed");
`else
`define IBSE_ASSERT(label, clk, rst, prop)
`define IBSE_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/core/ibse_pkg.sv
// Shared constants, states and controller/datapath interface types
// for the interleaved bitmap scroll engine. No dependencies.
package ibse_pkg;

   localparam int TEXT_ROWS = 24;
   localparam int MEM_BYTES = 6144;
   localparam int ADDR_W    = 13;
   localparam int DATA_W    = 8;
   localparam int ROW_W     = 5;
   localparam int IDX_W     = 8;   // scanline and column within one text row

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_SCROLL = 2'd2,
      CMD_UNUSED = 2'd3
   } ibse_cmd_code_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_FLUSH,
      ST_ZERO
   } ibse_state_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_IMM,
      RSP_READ,
      RSP_DONE
   } ibse_rsp_sel_type;

   // controller to datapath
   typedef struct packed {
      logic             clr_step;
      logic             acc_write;
      logic             acc_read;
      logic             load_scroll;
      logic             copy_step;
      logic             zero_init;
      logic             zero_step;
      ibse_rsp_sel_type rsp_sel;
   } ibse_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_write;
      logic is_read;
      logic is_scroll;
      logic addr_ok;
      logic scroll_ok;
      logic clr_done;
      logic byte_last;
      logic row_last;
   } ibse_status_type;

endpackage

>>> rtl/core/ibse_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ibse_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ibse_ctrl.sv
// Sequencer for the scroll engine: accept decode, clearing pass, copy and
// zero sweeps, result valid. Depends on ibse_pkg and the macro header.
`include "interleaved_bitmap_scroll_engine_macros.svh"
module ibse_ctrl
   import ibse_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ibse_status_type stat,
   output ibse_cmd_type    cmd
);

   ibse_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_fire;

   // accept only when idle and the result slot is free or draining
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (stat.is_read && stat.addr_ok) state_in = ST_READ;
               else if (stat.is_scroll && stat.scroll_ok) state_in = ST_COPY;
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_COPY: begin
            if (stat.byte_last && stat.row_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: state_in = ST_ZERO;
         ST_ZERO: begin
            if (stat.byte_last) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd         = '0;
      cmd.rsp_sel = RSP_NONE;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            if (req_fire) begin
               priority if (stat.is_write && stat.addr_ok) begin
                  cmd.acc_write = 1'b1;
                  cmd.rsp_sel   = RSP_IMM;
               end else if (stat.is_read && stat.addr_ok) begin
                  cmd.acc_read = 1'b1;
               end else if (stat.is_scroll && stat.scroll_ok) begin
                  cmd.load_scroll = 1'b1;
               end else begin
                  cmd.rsp_sel = RSP_IMM;
               end
            end
         end
         ST_READ:  cmd.rsp_sel   = RSP_READ;
         ST_COPY:  cmd.copy_step = 1'b1;
         ST_FLUSH: cmd.zero_init = 1'b1;
         ST_ZERO: begin
            cmd.zero_step = 1'b1;
            if (stat.byte_last) cmd.rsp_sel = RSP_DONE;
         end
         default: cmd = '0;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_sel != RSP_NONE) rsp_valid_in = 1'b1;
      else if (rsp_ready)          rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a new result never overwrites one that is still waiting
   `IBSE_ASSERT(a_no_overwrite, clock, reset, (cmd.rsp_sel != RSP_NONE) |-> (!rsp_valid_ff || rsp_ready))
   // nothing is accepted outside idle
   `IBSE_ASSERT(a_busy_no_accept, clock, reset, (state_ff != ST_IDLE) |-> !req_ready)
   // reset always restarts the clearing pass
   `IBSE_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (state_ff == ST_CLEAR))

endmodule

>>> rtl/core/ibse_datapath.sv
// Datapath of the scroll engine: request decode, sweep counters, bitmap RAM,
// copy write-back stage and result register. Depends on ibse_pkg, ibse_ram and the macro header.
`include "interleaved_bitmap_scroll_engine_macros.svh"
module ibse_datapath
   import ibse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_command,
   input  logic [ADDR_W-1:0]  req_byte_address,
   input  logic [DATA_W-1:0]  req_write_data,
   input  logic [7:0]         req_top_row,
   input  logic [7:0]         req_bottom_row,
   input  logic signed [7:0]  req_scroll_amount,
   input  ibse_cmd_type       cmd,
   output ibse_status_type    stat,
   output logic [DATA_W-1:0]  rsp_read_data,
   output logic               rsp_status
);

   // byte address of (text row, scanline/column index) in the thirds layout
   function automatic logic [ADDR_W-1:0] line_addr(input logic [ROW_W-1:0] row,
                                                   input logic [IDX_W-1:0] idx);
      line_addr = {row[4:3], idx[7:5], row[2:0], idx[4:0]};
   endfunction

   logic [ROW_W-1:0]  top_ff, bot_ff, row_ff, row_in;
   logic              up_ff;
   logic [IDX_W-1:0]  byte_ff, byte_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              pend_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [ROW_W-1:0]  src_row;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;
   ibse_cmd_code_type code;

   // request decode
   assign code           = ibse_cmd_code_type'(req_command);
   assign stat.is_write  = (code == CMD_WRITE);
   assign stat.is_read   = (code == CMD_READ);
   assign stat.is_scroll = (code == CMD_SCROLL);
   assign stat.addr_ok   = (req_byte_address < ADDR_W'(MEM_BYTES));
   assign stat.scroll_ok = (req_top_row < req_bottom_row)
                           && (req_bottom_row < 8'(TEXT_ROWS))
                           && (req_scroll_amount == 8'sd1 || req_scroll_amount == -8'sd1);

   // sweep status
   assign stat.clr_done  = (clr_addr_ff == ADDR_W'(MEM_BYTES - 1));
   assign stat.byte_last = (byte_ff == {IDX_W{1'b1}});
   assign stat.row_last  = up_ff ? ((row_ff + 1'b1) == bot_ff) : (row_ff == (top_ff + 1'b1));

   assign src_row = up_ff ? (row_ff + 1'b1) : (row_ff - 1'b1);

   // counters and latched region; the sweep commands are one-hot
   always_comb begin
      row_in      = row_ff;
      byte_in     = byte_ff;
      clr_addr_in = clr_addr_ff;
      if (cmd.clr_step) clr_addr_in = clr_addr_ff + 1'b1;
      if (cmd.load_scroll) begin
         row_in  = (req_scroll_amount == 8'sd1) ? req_top_row[ROW_W-1:0]
                                                 : req_bottom_row[ROW_W-1:0];
         byte_in = '0;
      end else if (cmd.zero_init) begin
         row_in  = up_ff ? bot_ff : top_ff;
         byte_in = '0;
      end else if (cmd.copy_step) begin
         byte_in = byte_ff + 1'b1;
         if (stat.byte_last) row_in = src_row;
      end else if (cmd.zero_step) begin
         byte_in = byte_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         pend_ff     <= cmd.copy_step;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      byte_ff <= byte_in;
      if (cmd.load_scroll) begin
         top_ff <= req_top_row[ROW_W-1:0];
         bot_ff <= req_bottom_row[ROW_W-1:0];
         up_ff  <= (req_scroll_amount == 8'sd1);
      end
      if (cmd.copy_step) pend_addr_ff <= line_addr(row_ff, byte_ff);
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // RAM ports: copy write-back has the write port to itself
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
      priority if (pend_ff) begin
         wr_addr = pend_addr_ff;
         wr_data = rd_data;
      end else if (cmd.clr_step) begin
         wr_addr = clr_addr_ff;
      end else if (cmd.acc_write) begin
         wr_addr = req_byte_address;
         wr_data = req_write_data;
      end else if (cmd.zero_step) begin
         wr_addr = line_addr(row_ff, byte_ff);
      end else begin
         wr_en = 1'b0;
      end
   end

   assign rd_en   = cmd.copy_step || cmd.acc_read;
   assign rd_addr = cmd.copy_step ? line_addr(src_row, byte_ff) : req_byte_address;

   ibse_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MEM_BYTES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // result register
   always_comb begin
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      unique case (cmd.rsp_sel)
         RSP_NONE: ;
         RSP_IMM: begin
            rsp_data_in   = '0;
            rsp_status_in = !(stat.is_write && stat.addr_ok);
         end
         RSP_READ: begin
            rsp_data_in   = rd_data;
            rsp_status_in = 1'b0;
         end
         RSP_DONE: begin
            rsp_data_in   = '0;
            rsp_status_in = 1'b0;
         end
         default: ;
      endcase
   end

   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

   // pending copy write never collides with another writer
   `IBSE_ASSERT(a_wr_port_free, clock, reset, pend_ff |-> !(cmd.clr_step || cmd.acc_write || cmd.zero_step))
   // copy destination stays inside the latched region
   `IBSE_ASSERT(a_row_in_region, clock, reset, cmd.copy_step |-> (row_ff >= top_ff && row_ff <= bot_ff))

endmodule

>>> rtl/core/interleaved_bitmap_scroll_engine.sv
// Top level of the interleaved bitmap scroll engine.
// Depends on ibse_pkg, ibse_ctrl, ibse_datapath (and ibse_ram below it).
//
// Usage:
//   req_* channel: one command beat (write byte, read byte, scroll region).
//   rsp_* channel: one result beat per command, read_data and status.
//   Both channels are valid/ready; a beat moves when valid and ready are high.
// Timing:
//   Writes, rejected commands and unused codes: result registered at the
//   accept edge; the next command is taken once that result slot is free
//   or draining. Reads: the byte passes the registered read port of the
//   bitmap RAM, then the result register. Scrolls: one byte moves per cycle
//   through the RAM read port and a write-back stage; then a flush state and
//   a zero sweep clear the vacated row, and the result is registered last.
// Reset:
//   Synchronous, active high. Afterwards a clearing pass zeroes all 6144
//   bytes of the bitmap, one byte a cycle; req_ready stays low until it ends.
// Stalls:
//   A result waits in its register while rsp_ready is low; a new command is
//   accepted only once that result is taken in the same or an earlier cycle.
module interleaved_bitmap_scroll_engine
   import ibse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [ADDR_W-1:0]  req_byte_address,
   input  logic [DATA_W-1:0]  req_write_data,
   input  logic [7:0]         req_top_row,
   input  logic [7:0]         req_bottom_row,
   input  logic signed [7:0]  req_scroll_amount,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DATA_W-1:0]  rsp_read_data,
   output logic               rsp_status
);

   ibse_cmd_type    cmd;
   ibse_status_type stat;

   // sequencer
   ibse_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // bitmap storage and counters
   ibse_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_byte_address (req_byte_address),
      .req_write_data   (req_write_data),
      .req_top_row      (req_top_row),
      .req_bottom_row   (req_bottom_row),
      .req_scroll_amount(req_scroll_amount),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status)
   );

endmodule

>>> tb/interleaved_bitmap_scroll_engine_tb.sv
// Self-checking testbench for the interleaved bitmap scroll engine: byte writes,
// byte reads and region scrolls against a bitmap mirror kept by a scoreboard class.
// Depends on ibse_pkg and the interleaved_bitmap_scroll_engine RTL.
module interleaved_bitmap_scroll_engine_tb
   import ibse_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RANDOM_ITEMS = 1850;
   localparam int          STALL_LIMIT  = 40000;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          ROW_BYTES    = 32;
   localparam int          SCANLINES    = 8;
   localparam logic        STATUS_DONE     = 1'b0;
   localparam logic        STATUS_REJECTED = 1'b1;
   localparam logic signed [7:0] SCROLL_UP   = 8'sd1;
   localparam logic signed [7:0] SCROLL_DOWN = -8'sd1;

   typedef struct packed {
      logic [7:0] read_data;
      logic       status;
   } engine_result_type;

   // Mirror of the bitmap plus the queue of results still owed by the block
   class scroll_engine_scoreboard;
      logic [7:0]        bitmap_mirror [MEM_BYTES];
      engine_result_type expected_results [$];
      int                failures;

      function new();
         foreach (bitmap_mirror[i]) bitmap_mirror[i] = '0;
         failures = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // thirds layout: third, then scanline, then row within the third
      function int unsigned line_base(int unsigned row, int unsigned scan);
         return (row >> 3) * 2048 + scan * 256 + (row & 7) * ROW_BYTES;
      endfunction

      function void move_row(int unsigned dst, int unsigned src);
         int unsigned d, s;
         for (int unsigned scan = 0; scan < SCANLINES; scan++) begin
            d = line_base(dst, scan);
            s = line_base(src, scan);
            for (int unsigned col = 0; col < ROW_BYTES; col++)
               bitmap_mirror[d + col] = bitmap_mirror[s + col];
         end
      endfunction

      function void blank_row(int unsigned row);
         int unsigned d;
         for (int unsigned scan = 0; scan < SCANLINES; scan++) begin
            d = line_base(row, scan);
            for (int unsigned col = 0; col < ROW_BYTES; col++)
               bitmap_mirror[d + col] = '0;
         end
      endfunction

      // returns 1 when the scroll is legal and applied
      function bit scroll_region(int unsigned top, int unsigned bottom,
                                 logic signed [7:0] amount);
         if (top >= bottom || bottom >= TEXT_ROWS) return 1'b0;
         if (amount == SCROLL_UP) begin
            for (int unsigned r = top; r < bottom; r++) move_row(r, r + 1);
            blank_row(bottom);
         end else if (amount == SCROLL_DOWN) begin
            for (int unsigned r = bottom; r > top; r--) move_row(r, r - 1);
            blank_row(top);
         end else begin
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // accepted command beat: update the mirror and queue the result it owes
      function void note_command(ibse_cmd_code_type cmd, logic [12:0] addr,
                                 logic [7:0] data, logic [7:0] top,
                                 logic [7:0] bottom, logic signed [7:0] amount);
         engine_result_type res;
         res.read_data = '0;
         res.status    = STATUS_REJECTED;
         case (cmd)
            CMD_WRITE: begin
               if (addr < MEM_BYTES) begin
                  bitmap_mirror[addr] = data;
                  res.status = STATUS_DONE;
               end
            end
            CMD_READ: begin
               if (addr < MEM_BYTES) begin
                  res.read_data = bitmap_mirror[addr];
                  res.status    = STATUS_DONE;
               end
            end
            CMD_SCROLL: begin
               if (scroll_region(32'(top), 32'(bottom), amount)) res.status = STATUS_DONE;
            end
            default: ;
         endcase
         expected_results.push_back(res);
      endfunction

      // accepted result beat: compare with the oldest expectation
      function void check_result(logic [7:0] read_data, logic status);
         engine_result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected: read_data %0h status %0b",
                     $time, read_data, status);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %0h actual %0h",
                     $time, want.read_data, read_data);
            failures++;
         end
         if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0b actual %0b",
                     $time, want.status, status);
            failures++;
         end
      endfunction
   endclass

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_ready;
   logic [1:0]        req_command       = CMD_WRITE;
   logic [ADDR_W-1:0] req_byte_address  = '0;
   logic [DATA_W-1:0] req_write_data    = '0;
   logic [7:0]        req_top_row       = '0;
   logic [7:0]        req_bottom_row    = '0;
   logic signed [7:0] req_scroll_amount = '0;
   logic              rsp_valid;
   logic              rsp_ready         = 1'b0;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_status;

   scroll_engine_scoreboard scoreboard;
   bit steady       = 1'b0;   // no idling on either side while set
   bit pressure_due = 1'b0;   // asks the receiver for its long hold-off
   int stall_cycles = 0;

   interleaved_bitmap_scroll_engine i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_byte_address  (req_byte_address),
      .req_write_data    (req_write_data),
      .req_top_row       (req_top_row),
      .req_bottom_row    (req_bottom_row),
      .req_scroll_amount (req_scroll_amount),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_status        (rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Drive one command beat at the falling edge, hold it until accepted
   task automatic send_command(ibse_cmd_code_type cmd, logic [12:0] addr,
                               logic [7:0] data, logic [7:0] top,
                               logic [7:0] bottom, logic signed [7:0] amount);
      while (!steady && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_byte_address  <= addr;
      req_write_data    <= data;
      req_top_row       <= top;
      req_bottom_row    <= bottom;
      req_scroll_amount <= amount;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scoreboard.note_command(cmd, addr, data, top, bottom, amount);
      @(negedge clock);
   endtask

   // Half the addresses land on a few columns of every line so reads hit data
   function automatic logic [12:0] random_address();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50)
         return 13'(scoreboard.line_base($urandom_range(TEXT_ROWS - 1), $urandom_range(7))
                    + $urandom_range(3));
      else if (pick < 90)
         return 13'($urandom_range(MEM_BYTES - 1));
      else
         return 13'($urandom_range(8191, MEM_BYTES));
   endfunction

   // Result side: random back-pressure plus one long hold-off
   initial begin : result_sink
      int  hold_left;
      bit  hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_due && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 26);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         scoreboard.check_result(rsp_read_data, rsp_status);
   end

   // Watchdog: cycles with no beat on either channel
   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("[interleaved_bitmap_scroll_engine] ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned       pick, kind, max_span, span;
      ibse_cmd_code_type cmd;
      logic [12:0]       addr;
      logic [7:0]        data, top, bottom;
      logic signed [7:0] amount;

      scoreboard = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: address extremes, rejects, unused code, full-height scrolls
      send_command(CMD_WRITE, 13'd0, 8'hFF, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_WRITE, 13'd6143, 8'hA5, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_WRITE, 13'd805, 8'h3C, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_WRITE, 13'd2048, 8'h11, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_WRITE, 13'd6144, 8'h5A, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_WRITE, 13'd8191, 8'hC3, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_READ, 13'd0, 8'h00, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_READ, 13'd6143, 8'h00, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_READ, 13'd6144, 8'h00, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_READ, 13'd8191, 8'hFF, 8'hFF, 8'hFF, -8'sd1);
      send_command(CMD_UNUSED, 13'd100, 8'hAA, 8'd0, 8'd23, 8'sd1);
      send_command(CMD_SCROLL, 13'd0, 8'h00, 8'd0, 8'd23, SCROLL_UP);
      send_command(CMD_READ, 13'd773, 8'h00, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_READ, 13'd0, 8'h00, 8'd0, 8'd0, 8'sd0);
      send_command(CMD_SCROLL, 13'd0, 8'h00, 8'd0, 8'd23, SCROLL_DOWN);
      send_command(CMD_READ, 13'd805, 8'h00, 8'd0, 8'd0, 8'sd0);
      // bad regions: equal rows, reversed rows, bottom past the last row
      send_command(CMD_SCROLL, 13'd0, 8'h00, 8'd5, 8'd5, SCROLL_UP);
      send_command(CMD_SCROLL, 13'd0, 8'h00, 8'd6, 8'd5, SCROLL_UP);
      send_command(CMD_SCROLL, 13'd0, 8'h00, 8'd0, 8'd24, SCROLL_DOWN);
      send_command(CMD_SCROLL, 13'd0, 8'h00, 8'd0, 8'd255, SCROLL_UP);
      // bad amounts on a legal region
      send_command(CMD_SCROLL, 13'd0, 8'h00, 8'd0, 8'd23, 8'sd0);
      send_command(CMD_SCROLL, 13'd0, 8'h00, 8'd0, 8'd23, 8'sd2);
      send_command(CMD_SCROLL, 13'd0, 8'h00, 8'd0, 8'd23, -8'sd128);
      send_command(CMD_SCROLL, 13'd0, 8'h00, 8'd0, 8'd23, 8'sd127);
      send_command(CMD_READ, 13'd2048, 8'h00, 8'd0, 8'd0, 8'sd0);

      // random traffic; unused fields carry random bits
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 500 && n < 800);
         if (n == 1200) pressure_due = 1'b1;
         pick   = $urandom_range(99);
         addr   = random_address();
         data   = 8'($urandom);
         top    = 8'($urandom);
         bottom = 8'($urandom);
         amount = 8'($urandom);
         if (pick < 40) begin
            cmd = CMD_WRITE;
         end else if (pick < 75) begin
            cmd = CMD_READ;
         end else if (pick < 95) begin
            cmd  = CMD_SCROLL;
            kind = $urandom_range(9);
            if (kind < 9) begin
               // legal region, mostly short spans, now and then a tall one
               top      = 8'($urandom_range(TEXT_ROWS - 2));
               max_span = TEXT_ROWS - 1 - top;
               if ($urandom_range(19) == 0)
                  span = $urandom_range(max_span, 1);
               else
                  span = $urandom_range((max_span < 3) ? max_span : 3, 1);
               bottom = 8'(top + span);
               if (kind < 8) amount = $urandom_range(1) ? SCROLL_UP : SCROLL_DOWN;
            end
         end else begin
            cmd = CMD_UNUSED;
         end
         send_command(cmd, addr, data, top, bottom, amount);
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      // drain, then a short quiet window for stray result beats
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (scoreboard.failures == 0 && scoreboard.pending() == 0)
         $display("[interleaved_bitmap_scroll_engine] OK");
      else
         $display("[interleaved_bitmap_scroll_engine] ERROR");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ibse_pkg.sv
rtl/core/ibse_ram.sv
rtl/core/ibse_ctrl.sv
rtl/core/ibse_datapath.sv
rtl/core/interleaved_bitmap_scroll_engine.sv
tb/interleaved_bitmap_scroll_engine_tb.sv
